/* design/grbc_pkg.sv */
package grbc_pkg;

  localparam int FONT_AW    = 13;
  localparam int FONT_DEPTH = 1 << FONT_AW;
  localparam int PIX_W      = 8;
  localparam int COLOR_W    = 8;
  localparam int GLYPH_IN_W = 8;
  localparam int COORD_W    = 16;
  localparam int SCR_W      = 13;
  localparam int GH_W       = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 13;

  localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 13'd480;
  localparam logic [GH_W-1:0]  GLYPH_HEIGHT_RST  = 6'd16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SCREEN_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_SCREEN_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_GLYPH_HEIGHT  = 2'd2;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam int IN_W          = 72;
  localparam int OUT_W         = 48;
  localparam int IN_ADDR_LSB   = 0;
  localparam int IN_BYTE_LSB   = 13;
  localparam int IN_GLYPH_LSB  = 21;
  localparam int IN_X_LSB      = 29;
  localparam int IN_Y_LSB      = 45;
  localparam int IN_COLOR_LSB  = 61;

  typedef enum logic {
    ST_IDLE,
    ST_DRAW
  } state_t;

  typedef struct packed {
    logic               en;
    logic [FONT_AW-1:0] addr;
    logic [PIX_W-1:0]   data;
  } font_wr_t;

  typedef struct packed {
    logic               en;
    logic [FONT_AW-1:0] addr;
  } font_rd_t;

endpackage

/* design/glyph_row_blitter_with_clipping_core.sv */
// A draw beat yields one row beat per glyph row: each row is read from the font
// RAM into the read stage, then moved to the output register, one row per cycle
// while m_tready is high. A draw holds the input until its rows (glyph_height, up
// to MAX_GLYPH_ROWS) have used the one font RAM read port; a load beat does not.
// Synchronous reset clears control and restores 640 x 480 screen, 16-row glyphs;
// font RAM contents are not cleared and must be loaded before a glyph is drawn.
module glyph_row_blitter_with_clipping_core #(
  parameter int GLYPH_COUNT    = 256,
  parameter int MAX_GLYPH_ROWS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // font_addr[12:0], font_byte[20:13], glyph_index[28:21], pos_x[44:29],
  // pos_y[60:45], ink_color[68:61], zero fill [71:69]
  input  logic [grbc_pkg::IN_W-1:0]           s_tdata,
  // cmd[0]
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // row_y[15:0], left_x[31:16], pixel_mask[39:32], pixel_color[47:40]
  output logic [grbc_pkg::OUT_W-1:0]          m_tdata,
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [grbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [grbc_pkg::CFG_W-1:0]          cfg_data
);
  import grbc_pkg::*;

  localparam int ROW_W  = $clog2(MAX_GLYPH_ROWS + 1);
  localparam int LIM_W  = (ROW_W > GH_W) ? ROW_W : GH_W;
  localparam int GCNT_W = $clog2(GLYPH_COUNT + 1);
  localparam int GLY_W  = (GCNT_W > GLYPH_IN_W) ? GCNT_W : GLYPH_IN_W;
  localparam int BASE_W = GLY_W + GH_W;

  logic [SCR_W-1:0] screen_width;
  logic [SCR_W-1:0] screen_height;
  logic [GH_W-1:0]  glyph_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
      glyph_height  <= GLYPH_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[SCR_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data[SCR_W-1:0];
        CFG_GLYPH_HEIGHT:  glyph_height  <= cfg_data[GH_W-1:0];
        default: ;
      endcase
    end
  end

  logic                    in_cmd;
  logic [FONT_AW-1:0]      in_font_addr;
  logic [PIX_W-1:0]        in_font_byte;
  logic [GLYPH_IN_W-1:0]   in_glyph;
  logic [COORD_W-1:0]      in_pos_x;
  logic [COORD_W-1:0]      in_pos_y;
  logic [COLOR_W-1:0]      in_color;

  assign in_cmd       = s_tuser;
  assign in_font_addr = s_tdata[IN_ADDR_LSB +: FONT_AW];
  assign in_font_byte = s_tdata[IN_BYTE_LSB +: PIX_W];
  assign in_glyph     = s_tdata[IN_GLYPH_LSB +: GLYPH_IN_W];
  assign in_pos_x     = s_tdata[IN_X_LSB +: COORD_W];
  assign in_pos_y     = s_tdata[IN_Y_LSB +: COORD_W];
  assign in_color     = s_tdata[IN_COLOR_LSB +: COLOR_W];

  state_t state, state_next;
  logic   accept, draw_acc, load_acc;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign draw_acc = accept && (in_cmd == CMD_DRAW);
  assign load_acc = accept && (in_cmd == CMD_LOAD);

  logic [LIM_W-1:0] gh_ext;
  logic [ROW_W-1:0] rows_lim;

  assign gh_ext   = LIM_W'(glyph_height);
  assign rows_lim = (gh_ext > LIM_W'(MAX_GLYPH_ROWS)) ? ROW_W'(MAX_GLYPH_ROWS)
                                                      : gh_ext[ROW_W-1:0];

  logic [GLY_W-1:0]  glyph_ext, glyph_mod;
  logic [BASE_W-1:0] base_full;

  assign glyph_ext = GLY_W'(in_glyph);
  assign glyph_mod = (glyph_ext >= GLY_W'(GLYPH_COUNT)) ? glyph_ext - GLY_W'(GLYPH_COUNT)
                                                        : glyph_ext;
  assign base_full = BASE_W'(glyph_mod) * BASE_W'(glyph_height);

  logic [PIX_W-1:0] col_mask;

  always_comb begin
    logic [COORD_W:0] xc;
    col_mask = '0;
    for (int i = 0; i < PIX_W; i++) begin
      xc = {in_pos_x[COORD_W-1], in_pos_x} + (COORD_W+1)'(i);
      col_mask[PIX_W-1-i] = !xc[COORD_W] &&
                            (xc[COORD_W-1:0] < COORD_W'(screen_width));
    end
  end

  logic [ROW_W-1:0]   row, rows;
  logic [FONT_AW-1:0] base;
  logic [COORD_W-1:0] held_x, held_y;
  logic [COLOR_W-1:0] held_color;
  logic [PIX_W-1:0]   held_cmask;

  always_ff @(posedge clk) begin
    if (draw_acc) begin
      rows       <= rows_lim;
      base       <= base_full[FONT_AW-1:0];
      held_x     <= in_pos_x;
      held_y     <= in_pos_y;
      held_color <= in_color;
      held_cmask <= col_mask;
    end
  end

  logic rd_valid, rd_free, move, issue, last_issue;

  assign move       = rd_valid && (!m_tvalid || m_tready);
  assign rd_free    = !rd_valid || move;
  assign last_issue = (row == rows - ROW_W'(1));

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (draw_acc && (rows_lim != '0)) begin
          state_next = ST_DRAW;
        end
      end
      ST_DRAW: begin
        issue = rd_free;
        if (rd_free && last_issue) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row   <= '0;
    end else begin
      state <= state_next;
      if (draw_acc) begin
        row <= '0;
      end else if (issue) begin
        row <= row + ROW_W'(1);
      end
    end
  end

  logic [COORD_W:0] yc;
  logic             y_vis;

  assign yc    = {held_y[COORD_W-1], held_y} + (COORD_W+1)'(row);
  assign y_vis = !yc[COORD_W] && (yc[COORD_W-1:0] < COORD_W'(screen_height));

  font_wr_t         font_wr;
  font_rd_t         font_rd;
  logic [PIX_W-1:0] font_q;

  assign font_wr.en   = load_acc;
  assign font_wr.addr = in_font_addr;
  assign font_wr.data = in_font_byte;
  assign font_rd.en   = issue;
  assign font_rd.addr = base + FONT_AW'(row);

  grbc_font_ram u_font_ram (
    .clk   (clk),
    .wr    (font_wr),
    .rd    (font_rd),
    .rdata (font_q)
  );

  logic [COORD_W-1:0] rd_y, rd_x;
  logic               rd_yvis, rd_last;
  logic [COLOR_W-1:0] rd_color;
  logic [PIX_W-1:0]   rd_cmask;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue || (rd_valid && !move);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_y     <= yc[COORD_W-1:0];
      rd_yvis  <= y_vis;
      rd_last  <= last_issue;
      rd_x     <= held_x;
      rd_color <= held_color;
      rd_cmask <= held_cmask;
    end
  end

  logic [COORD_W-1:0] out_y, out_x;
  logic [PIX_W-1:0]   out_mask;
  logic [COLOR_W-1:0] out_color;
  logic               out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= move || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_y     <= rd_y;
      out_x     <= rd_x;
      out_mask  <= rd_yvis ? (font_q & rd_cmask) : '0;
      out_color <= rd_color;
      out_last  <= rd_last;
    end
  end

  assign m_tdata = {out_color, out_mask, out_x, out_y};
  assign m_tlast = out_last;

  a_ram_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(font_wr.en && font_rd.en))
    else $error("font load collides with a row read");

  a_draw_start: assert property (@(posedge clk) disable iff (rst)
    draw_acc && (rows_lim != '0) |=> (state == ST_DRAW) && (row == '0))
    else $error("draw did not start at row zero");

  a_last_exit: assert property (@(posedge clk) disable iff (rst)
    issue && last_issue |=> (state == ST_IDLE))
    else $error("draw kept running past its last row");

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    rd_valid && !move |=> rd_valid && $stable(rd_y) && $stable(rd_last))
    else $error("pending row read was overwritten");

endmodule

/* design/grbc_font_ram.sv */
module grbc_font_ram (
  input  logic                         clk,
  input  grbc_pkg::font_wr_t           wr,
  input  grbc_pkg::font_rd_t           rd,
  output logic [grbc_pkg::PIX_W-1:0]   rdata
);
  import grbc_pkg::*;

  logic [PIX_W-1:0] mem [FONT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule
